// ===== design/multichannel_adc_median_prefilter_unit_defines.svh =====
// assertion macros for the multichannel adc median prefilter
// used by the top level; expects clk and rst_n in scope
`ifndef MULTICHANNEL_ADC_MEDIAN_PREFILTER_UNIT_DEFINES_SVH
`define MULTICHANNEL_ADC_MEDIAN_PREFILTER_UNIT_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define MAMP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define MAMP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mamp_pkg.sv =====
// shared widths, codes and types of the multichannel adc median prefilter
// no dependencies
`default_nettype none

package mamp_pkg;

  localparam int CHANNELS = 8;
  localparam int RAW_W    = 16;
  localparam int SAMPLE_W = 12;
  localparam int CH_W     = 3;
  localparam int CFG_W    = 6;

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_row_t;

endpackage

`default_nettype wire

// ===== design/mamp_in_if.sv =====
// request channel: valid/ready plus one row or read request
// depends on mamp_pkg
`default_nettype none

interface mamp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [mamp_pkg::CH_W-1:0]  read_channel;
  logic [mamp_pkg::RAW_W-1:0] raw_ch0;
  logic [mamp_pkg::RAW_W-1:0] raw_ch1;
  logic [mamp_pkg::RAW_W-1:0] raw_ch2;
  logic [mamp_pkg::RAW_W-1:0] raw_ch3;
  logic [mamp_pkg::RAW_W-1:0] raw_ch4;
  logic [mamp_pkg::RAW_W-1:0] raw_ch5;
  logic [mamp_pkg::RAW_W-1:0] raw_ch6;
  logic [mamp_pkg::RAW_W-1:0] raw_ch7;

  modport source (
    output valid, action, read_channel,
    output raw_ch0, raw_ch1, raw_ch2, raw_ch3, raw_ch4, raw_ch5, raw_ch6, raw_ch7,
    input  ready
  );
  modport sink (
    input  valid, action, read_channel,
    input  raw_ch0, raw_ch1, raw_ch2, raw_ch3, raw_ch4, raw_ch5, raw_ch6, raw_ch7,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/mamp_out_if.sv =====
// result channel: valid/ready plus one median value
// depends on mamp_pkg
`default_nettype none

interface mamp_out_if;
  logic                          valid;
  logic                          ready;
  logic [mamp_pkg::SAMPLE_W-1:0] median_value;

  modport source (output valid, median_value, input ready);
  modport sink   (input valid, median_value, output ready);
endinterface

`default_nettype wire

// ===== design/multichannel_adc_median_prefilter_unit.sv =====
// store request: taken back to back; read request: run time for depth n set by the
// rank-count loop through one compare unit and the single read port of the row memory;
// block takes no request while a read runs
// result sits in an output register, so the next request is taken while it waits
// synchronous active-low reset: depth 0, row 0, all row valid bits clear (store reads zero)
// depends on mamp_pkg, mamp_in_if, mamp_out_if and the defines header
`default_nettype none

`include "multichannel_adc_median_prefilter_unit_defines.svh"

module multichannel_adc_median_prefilter_unit #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mamp_in_if.sink                    in_ch,
  mamp_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [mamp_pkg::CFG_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // taking requests
  localparam logic [2:0] S_FETCH = 3'd1;  // candidate row address out
  localparam logic [2:0] S_LATCH = 3'd2;  // candidate sample back, hold it
  localparam logic [2:0] S_SCAN  = 3'd3;  // one row per cycle through the comparator
  localparam logic [2:0] S_TAIL  = 3'd4;  // last compare of the sweep
  localparam logic [2:0] S_CHECK = 3'd5;  // rank test on the counts
  localparam logic [2:0] S_EMIT  = 3'd6;  // wait for a free output register

  // configuration and depth in use
  logic [mamp_pkg::CFG_W-1:0] samples_in_use_r;
  logic [CNT_W-1:0]           depth;
  logic [CNT_W-1:0]           last_idx;
  logic [CNT_W-1:0]           rank;

  always_comb begin
    if (32'(samples_in_use_r) > 32'(MAX_SAMPLES)) begin
      depth = CNT_W'(MAX_SAMPLES);
    end else begin
      depth = CNT_W'(samples_in_use_r);
    end
  end

  assign last_idx = depth - 1'b1;
  assign rank     = last_idx >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_in_use_r <= '0;
    end else if (cfg_we) begin
      samples_in_use_r <= cfg_data;
    end
  end

  // request decode
  logic in_fire;
  logic store_fire;

  assign in_fire    = in_ch.valid & in_ch.ready;
  assign store_fire = in_fire & (in_ch.action == mamp_pkg::ACT_STORE) & (depth != '0);

  // row pointer, wraps at the depth in use
  logic [ADDR_W-1:0] row_pos_r;
  logic [ADDR_W-1:0] row_pos_nxt;
  logic [ADDR_W-1:0] wr_pos;
  logic [CNT_W-1:0]  pos_inc;

  assign wr_pos  = (CNT_W'(row_pos_r) < depth) ? row_pos_r : '0;
  assign pos_inc = CNT_W'(wr_pos) + 1'b1;
  assign row_pos_nxt = (pos_inc >= depth) ? '0 : ADDR_W'(pos_inc);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      row_pos_r <= '0;
    end else if (store_fire) begin
      row_pos_r <= row_pos_nxt;
    end
  end

  // incoming row: bits 15:4 of each channel word
  mamp_pkg::sample_row_t wr_row;

  always_comb begin
    wr_row[0] = in_ch.raw_ch0[15:4];
    wr_row[1] = in_ch.raw_ch1[15:4];
    wr_row[2] = in_ch.raw_ch2[15:4];
    wr_row[3] = in_ch.raw_ch3[15:4];
    wr_row[4] = in_ch.raw_ch4[15:4];
    wr_row[5] = in_ch.raw_ch5[15:4];
    wr_row[6] = in_ch.raw_ch6[15:4];
    wr_row[7] = in_ch.raw_ch7[15:4];
  end

  // row memory, one write and one registered read a cycle
  // a row without its valid bit has not been written since the last clear and reads as zero
  mamp_pkg::sample_row_t row_mem [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] row_valid_r;
  logic [ADDR_W-1:0]      rd_addr;
  mamp_pkg::sample_row_t  rd_row_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (store_fire) begin
      row_mem[wr_pos] <= wr_row;
    end
    rd_row_r   <= row_mem[rd_addr];
    rd_valid_r <= row_valid_r[rd_addr];
  end

  // a register write restarts the filter with an empty store
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      row_valid_r <= '0;
    end else if (store_fire) begin
      row_valid_r[wr_pos] <= 1'b1;
    end
  end

  // sequencer state
  logic [2:0]                state_r, state_nxt;
  logic [ADDR_W-1:0]         i_r, i_nxt;       // candidate row
  logic [ADDR_W-1:0]         j_r, j_nxt;       // row being compared
  logic                      pend_r, pend_nxt; // read data holds a compare row
  logic [CNT_W-1:0]          below_r, below_nxt;
  logic [CNT_W-1:0]          upto_r, upto_nxt;
  mamp_pkg::sample_t         v_r, v_nxt;       // candidate value, later the result
  logic [mamp_pkg::CH_W-1:0] ch_r, ch_nxt;
  logic                      out_valid_r, out_valid_nxt;
  mamp_pkg::sample_t         out_median_r, out_median_nxt;

  mamp_pkg::sample_t cur_sample;
  logic              hit;
  logic              out_free;

  assign cur_sample = rd_valid_r ? rd_row_r[ch_r] : '0;
  assign hit        = (below_r <= rank) && (rank < upto_r);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign rd_addr    = (state_r == S_FETCH) ? i_r : j_r;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.median_value = out_median_r;

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    pend_nxt       = pend_r;
    below_nxt      = below_r;
    upto_nxt       = upto_r;
    v_nxt          = v_r;
    ch_nxt         = ch_r;
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // shared comparator: one stored sample against the candidate
    if (pend_r && (state_r == S_SCAN || state_r == S_TAIL)) begin
      if (cur_sample < v_r) begin
        below_nxt = below_r + 1'b1;
      end
      if (cur_sample <= v_r) begin
        upto_nxt = upto_r + 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.action == mamp_pkg::ACT_READ) begin
          ch_nxt = in_ch.read_channel;
          i_nxt  = '0;
          if (depth == '0) begin
            // filter off: answer zero
            v_nxt     = '0;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        v_nxt     = cur_sample;
        j_nxt     = '0;
        pend_nxt  = 1'b0;
        below_nxt = '0;
        upto_nxt  = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        pend_nxt = 1'b1;
        if (CNT_W'(j_r) == last_idx) begin
          state_nxt = S_TAIL;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_TAIL: begin
        pend_nxt  = 1'b0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // the lower median is always found by the last candidate
        if (hit || CNT_W'(i_r) == last_idx) begin
          state_nxt = S_EMIT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_median_nxt = v_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    below_r      <= below_nxt;
    upto_r       <= upto_nxt;
    v_r          <= v_nxt;
    ch_r         <= ch_nxt;
    out_median_r <= out_median_nxt;
  end

  // checks on the sequencer and row pointer
  `MAMP_ASSERT_NOW(a_counts_ordered, state_r == S_CHECK, below_r <= upto_r, "below count above upto count")
  `MAMP_ASSERT_NOW(a_cand_in_range, state_r == S_CHECK, CNT_W'(i_r) < depth, "candidate row beyond depth")
  `MAMP_ASSERT_NEXT(a_off_read_zero, in_fire && in_ch.action == mamp_pkg::ACT_READ && depth == '0, state_r == S_EMIT && v_r == '0, "disabled read not answered with zero")
  `MAMP_ASSERT_NEXT(a_row_wraps, store_fire && !cfg_we, CNT_W'(row_pos_r) < depth, "row pointer left the depth in use")

endmodule

`default_nettype wire
